>>> rtl/gtw_rtc_pkg.sv
// Shared types, codes and helpers for the three-wire RTC behind the GPIO port.
// Holds BCD conversion, the command length table and the link interface structs.
// No dependencies.
`default_nettype none

package gtw_rtc_pkg;

    // Port register select codes carried in an item
    localparam logic [1:0] REG_PIN_DATA = 2'd0;
    localparam logic [1:0] REG_PIN_DIR  = 2'd1;
    localparam logic [1:0] REG_READ_EN  = 2'd2;

    // RTC command selects (command byte bits 6..4)
    localparam logic [2:0] CMD_SEL_CLEAR = 3'd0;
    localparam logic [2:0] CMD_SEL_DATE  = 3'd2;
    localparam logic [2:0] CMD_SEL_CTRL  = 3'd4;
    localparam logic [2:0] CMD_SEL_HMS   = 3'd6;

    localparam int unsigned TIME_BYTE_COUNT = 7;
    localparam logic [3:0]  CMD_MAGIC       = 4'h6;
    localparam logic [7:0]  CTRL_RESET      = 8'h40;
    localparam int unsigned CTRL_HOUR24_BIT = 6;
    localparam logic [3:0]  PIN_CLK_SEL     = 4'b0101;
    localparam logic [3:0]  PIN_CLK         = 4'b0001;

    // Current calendar values, binary
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } calendar_t;

    // Pin drive request from the RTC side
    typedef struct packed {
        logic       req;
        logic [3:0] pins;
    } pin_drive_t;

    // Number of data bytes that follow a command byte
    function automatic logic [2:0] cmd_len(input logic [2:0] sel);
        logic [2:0] len;
        unique case (sel)
            CMD_SEL_DATE: len = 3'(TIME_BYTE_COUNT);
            CMD_SEL_CTRL: len = 3'd1;
            CMD_SEL_HMS:  len = 3'd3;
            default:      len = 3'd0;
        endcase
        return len;
    endfunction

    // Two-digit BCD; hundreds dropped. Divide by 10 via 205/2048.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = 15'(v) * 15'd205;
        tens  = prod[14:11];
        units = v - (7'(tens) * 7'd10);
        if (tens >= 4'd10)
        begin
            tens = tens - 4'd10;
        end
        return {tens, units[3:0]};
    endfunction

    // Hour folded into 0..11
    function automatic logic [4:0] hour_mod12(input logic [4:0] h);
        logic [4:0] r;
        if (h >= 5'd24)
        begin
            r = h - 5'd24;
        end
        else if (h >= 5'd12)
        begin
            r = h - 5'd12;
        end
        else
        begin
            r = h;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gpio_three_wire_rtc.sv
// Top level: 4-pin GPIO port registers with a three-wire serial RTC on the pins.
// Depends on gtw_rtc_pkg and gtw_rtc_link.
//
// Each input item is one write to the pin data, pin direction or readback enable
// register; each item gives exactly one result item with the readback values.
// An item's state update is computed in the cycle it is accepted, and its result is
// held in an output register and shown from the next cycle. The result register
// is the only stage, so in_ready is high whenever that register is empty or being
// taken, and a new item is accepted every cycle while out_ready is held high.
`default_nettype none

module gpio_three_wire_rtc
    import gtw_rtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] command,
    input  wire logic [3:0] wdata,
    input  wire logic [6:0] year,
    input  wire logic [3:0] month,
    input  wire logic [4:0] day_of_month,
    input  wire logic [2:0] weekday,
    input  wire logic [4:0] hour,
    input  wire logic [5:0] minute,
    input  wire logic [5:0] second,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      pin_readback,
    output logic [3:0]      dir_readback,
    output logic            readback_on
);

    logic        accept;
    logic        pin_step;
    logic [3:0]  lvl_reg, lvl_next;
    logic [3:0]  dir_reg, dir_next;
    logic        ren_reg, ren_next;
    logic [3:0]  lvl_wr;
    logic        out_valid_reg;
    logic [3:0]  pin_rb_reg;
    logic [3:0]  dir_rb_reg;
    logic        ren_rb_reg;
    calendar_t   cal;
    pin_drive_t  drive;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign pin_step = accept && (command == REG_PIN_DATA);

    assign cal = '{year: year, month: month, day_of_month: day_of_month,
                   weekday: weekday, hour: hour, minute: minute, second: second};

    // Pin levels after a data write, before the RTC answers
    assign lvl_wr = (lvl_reg & ~dir_reg) | (wdata & dir_reg);

    gtw_rtc_link u_link (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (pin_step),
        .pins  (lvl_wr),
        .cal   (cal),
        .drive (drive)
    );

    // Port register update for the accepted item
    always_comb
    begin
        lvl_next = lvl_reg;
        dir_next = dir_reg;
        ren_next = ren_reg;
        if (accept)
        begin
            unique case (command)
                REG_PIN_DATA:
                begin
                    // RTC may drive the input pins back
                    if (drive.req && ren_reg)
                    begin
                        lvl_next = (lvl_wr & dir_reg) | (drive.pins & ~dir_reg);
                    end
                    else
                    begin
                        lvl_next = lvl_wr;
                    end
                end
                REG_PIN_DIR: dir_next = wdata;
                REG_READ_EN: ren_next = wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Port state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvl_reg       <= '0;
            dir_reg       <= '0;
            ren_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            pin_rb_reg    <= '0;
            dir_rb_reg    <= '0;
            ren_rb_reg    <= 1'b0;
        end
        else
        begin
            lvl_reg <= lvl_next;
            dir_reg <= dir_next;
            ren_reg <= ren_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                pin_rb_reg    <= ren_next ? lvl_next : 4'd0;
                dir_rb_reg    <= ren_next ? dir_next : 4'd0;
                ren_rb_reg    <= ren_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pin_readback = pin_rb_reg;
    assign dir_readback = dir_rb_reg;
    assign readback_on  = ren_rb_reg;

endmodule

`default_nettype wire

>>> rtl/gtw_rtc_link.sv
// Serial link state machine of the three-wire RTC: start sequence, bit shifting,
// command decode, BCD time latch and control register. Uses gtw_rtc_pkg.
`default_nettype none

module gtw_rtc_link
    import gtw_rtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [3:0] pins,
    input  wire calendar_t  cal,
    output pin_drive_t      drive
);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_START  = 2'd1,
        PH_ACTIVE = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  left_reg, left_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic        active_reg, active_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  tb_reg  [TIME_BYTE_COUNT];
    logic [7:0]  tb_next [TIME_BYTE_COUNT];

    logic [2:0]  left_dec;
    logic [3:0]  bit_inc;
    logic [2:0]  tb_idx;
    logic [7:0]  out_byte;
    logic        out_bit;
    logic [2:0]  new_sel;
    logic [2:0]  len_new;
    logic        act_new;
    logic [7:0]  cmd_new;

    // Data bit the clock drives on a read
    always_comb
    begin
        tb_idx   = 3'(TIME_BYTE_COUNT - 32'(left_reg));
        out_byte = '0;
        if (cmd_reg[6:4] == CMD_SEL_CTRL)
        begin
            out_byte = ctrl_reg;
        end
        else if (cmd_reg[6:4] == CMD_SEL_DATE || cmd_reg[6:4] == CMD_SEL_HMS)
        begin
            if (left_reg != 3'd0)
            begin
                out_byte = tb_reg[tb_idx];
            end
        end
        out_bit = active_reg && !bit_reg[3] && out_byte[bit_reg[2:0]];
    end

    // Next state for one pin update
    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        cmd_next    = cmd_reg;
        active_next = active_reg;
        ctrl_next   = ctrl_reg;
        tb_next     = tb_reg;
        drive       = '0;
        left_dec    = (left_reg != 3'd0) ? left_reg - 3'd1 : 3'd0;
        bit_inc     = bit_reg + 4'd1;
        new_sel     = shift_reg[6:4];
        len_new     = left_dec;
        act_new     = active_reg;
        cmd_new     = cmd_reg;

        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if ((pins & PIN_CLK_SEL) == PIN_CLK)
                    begin
                        phase_next = PH_START;
                    end
                    drive = '{req: 1'b1, pins: PIN_CLK};
                end
                PH_START:
                begin
                    phase_next = ((pins & PIN_CLK_SEL) == PIN_CLK_SEL) ? PH_ACTIVE : PH_IDLE;
                    drive      = '{req: 1'b1, pins: PIN_CLK_SEL};
                end
                PH_ACTIVE:
                begin
                    if (!pins[0])
                    begin
                        // clock low: sample data line
                        if (!bit_reg[3])
                        begin
                            shift_next[bit_reg[2:0]] = pins[1];
                        end
                    end
                    else if (pins[2])
                    begin
                        bit_next = bit_inc;
                        if (!cmd_reg[7])
                        begin
                            // write direction: a full byte closes here
                            if (bit_inc[3])
                            begin
                                if (!active_reg)
                                begin
                                    if (shift_reg[3:0] == CMD_MAGIC)
                                    begin
                                        cmd_new = shift_reg;
                                        len_new = cmd_len(new_sel);
                                        act_new = (len_new != 3'd0);
                                        if (new_sel == CMD_SEL_CLEAR)
                                        begin
                                            ctrl_next = '0;
                                        end
                                        else if (new_sel == CMD_SEL_DATE || new_sel == CMD_SEL_HMS)
                                        begin
                                            tb_next[0] = to_bcd(cal.year);
                                            tb_next[1] = to_bcd(7'(cal.month));
                                            tb_next[2] = to_bcd(7'(cal.day_of_month));
                                            tb_next[3] = to_bcd(7'(cal.weekday));
                                            tb_next[4] = ctrl_reg[CTRL_HOUR24_BIT]
                                                       ? to_bcd(7'(cal.hour))
                                                       : to_bcd(7'(hour_mod12(cal.hour)));
                                            tb_next[5] = to_bcd(7'(cal.minute));
                                            tb_next[6] = to_bcd(7'(cal.second));
                                        end
                                    end
                                end
                                else if (cmd_reg[6:4] == CMD_SEL_CTRL)
                                begin
                                    ctrl_next = shift_reg;
                                end
                                shift_next = '0;
                                bit_next   = '0;
                                left_next  = len_new;
                                if (len_new == 3'd0)
                                begin
                                    active_next = 1'b0;
                                    cmd_next    = '0;
                                end
                                else
                                begin
                                    active_next = act_new;
                                    cmd_next    = cmd_new;
                                end
                            end
                        end
                        else
                        begin
                            // read direction: clock drives the data line
                            drive = '{req: 1'b1, pins: {2'b01, out_bit, 1'b1}};
                            if (bit_inc[3])
                            begin
                                left_next = left_dec;
                                if (left_dec == 3'd0)
                                begin
                                    active_next = 1'b0;
                                    cmd_next    = '0;
                                end
                                bit_next = '0;
                            end
                        end
                    end
                    else
                    begin
                        // select dropped with clock high: link closes
                        bit_next    = '0;
                        left_next   = '0;
                        active_next = 1'b0;
                        cmd_next    = '0;
                        phase_next  = PH_START;
                        drive       = '{req: 1'b1, pins: PIN_CLK};
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bit_reg    <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            cmd_reg    <= '0;
            active_reg <= 1'b0;
            ctrl_reg   <= CTRL_RESET;
            for (int i = 0; i < TIME_BYTE_COUNT; i++)
            begin
                tb_reg[i] <= '0;
            end
        end
        else
        begin
            phase_reg  <= phase_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            left_reg   <= left_next;
            cmd_reg    <= cmd_next;
            active_reg <= active_next;
            ctrl_reg   <= ctrl_next;
            tb_reg     <= tb_next;
        end
    end

endmodule

`default_nettype wire
